// File: rtl/mwst_pkg.sv
// Shared constants and types for the maximum window sum tracker.
`timescale 1ns / 1ps

package mwst_pkg;

    // Delay line depth and the address width that follows from it.
    localparam int WINDOW_MAX  = 256;
    localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
    localparam int SAMPLE_BITS = 16;
    localparam int POS_BITS    = 16;
    localparam int SUM_BITS    = 24;
    localparam int WS_BITS     = 9;
    // The sample count is one bit wider so that it can saturate at 2**POS_BITS.
    localparam int CNT_BITS    = POS_BITS + 1;

    localparam logic [WS_BITS-1:0]  WS_RESET   = WS_BITS'(4);
    localparam logic [WS_BITS-1:0]  WS_MAX     = WS_BITS'(WINDOW_MAX);
    localparam logic [CNT_BITS-1:0] CNT_LIMIT  = CNT_BITS'(1) << POS_BITS;
    localparam logic [POS_BITS-1:0] POS_SAT    = {POS_BITS{1'b1}};

    // One sample on its way from the address stage to the accumulate stage.
    typedef struct packed {
        logic                          first;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sub_old;
        logic                          full;
        logic [POS_BITS-1:0]           start_pos;
        logic [POS_BITS-1:0]           end_pos;
    } s1_item_t;

endpackage

// File: rtl/max_window_sum_tracker.sv
// Top level of the maximum window sum tracker.
`timescale 1ns / 1ps

// Input beats carry one signed sample on s_tdata, with s_tuser high on the
// first sample of a new sequence. Each input beat gives exactly one output
// beat: m_tuser says whether the window is full, m_tdata carries the current
// window sum, the best full-window sum of the sequence and that window's first
// and last positions.
// An input beat is registered in the address stage with the delay line read
// of the sample leaving the window; the add and compare then feed the output
// register. Throughput is one beat per cycle while m_tready stays high, set by
// the single read and write port of the delay line memory. When the receiver
// holds m_tready low with a beat in the output register, that register and the
// address stage hold their beats and s_tready falls; nothing is dropped.
// After reset the window size is 4 and the sequence starts at position zero;
// the delay line needs no clearing pass as only entries of the current sequence
// are ever used. Writing the window size restarts the sequence; the user must
// write it only while no beat is in flight, which the block does not enforce.
module max_window_sum_tracker (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: sample [15:0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,
    // s_tuser: first [0]
    input  logic                             s_tuser,
    // m_tdata: window_sum [23:0], best_sum [47:24], best_start [63:48], best_end [79:64]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [79:0]                      m_tdata,
    // m_tuser: window_full [0]
    output logic                             m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [mwst_pkg::WS_BITS-1:0]     cfg_wr_data
);

    import mwst_pkg::*;

    logic                   pipe_en;
    logic                   accept;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_wr_addr;
    logic [SAMPLE_BITS-1:0] ram_wr_data;
    logic [ADDR_BITS-1:0]   ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;
    logic                   s1_valid;
    s1_item_t               s1_item;
    logic [SUM_BITS-1:0]    out_sum;
    logic [SUM_BITS-1:0]    out_best_sum;
    logic [POS_BITS-1:0]    out_best_start;
    logic [POS_BITS-1:0]    out_best_end;

    assign s_tready = pipe_en;
    assign accept   = s_tvalid && pipe_en;

    // Address stage.
    mwst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pipe_en     (pipe_en),
        .accept      (accept),
        .in_first    (s_tuser),
        .in_sample   (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item)
    );

    // Delay line of the last WINDOW_MAX samples.
    mwst_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_delay_line (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .re      (accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Accumulate stage and output register.
    mwst_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .old_sample     (ram_rd_data),
        .cfg_wr_en      (cfg_wr_en),
        .out_ready      (m_tready),
        .pipe_en        (pipe_en),
        .out_valid      (m_tvalid),
        .out_full       (m_tuser),
        .out_sum        (out_sum),
        .out_best_sum   (out_best_sum),
        .out_best_start (out_best_start),
        .out_best_end   (out_best_end)
    );

    assign m_tdata = {out_best_end, out_best_start, out_best_sum, out_sum};

endmodule

// File: rtl/mwst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mwst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read of the entry being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// File: rtl/mwst_front.sv
// Address stage: window size, write pointer, sample count and delay line addressing.
`timescale 1ns / 1ps

module mwst_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pipe_en,
    input  logic                              accept,
    input  logic                              in_first,
    input  logic [mwst_pkg::SAMPLE_BITS-1:0]  in_sample,
    input  logic                              cfg_wr_en,
    input  logic [mwst_pkg::WS_BITS-1:0]      cfg_wr_data,
    output logic                              ram_we,
    output logic [mwst_pkg::ADDR_BITS-1:0]    ram_wr_addr,
    output logic [mwst_pkg::SAMPLE_BITS-1:0]  ram_wr_data,
    output logic [mwst_pkg::ADDR_BITS-1:0]    ram_rd_addr,
    output logic                              s1_valid,
    output mwst_pkg::s1_item_t                s1_item
);

    import mwst_pkg::*;

    logic [WS_BITS-1:0]   window_size_reg;
    logic [ADDR_BITS-1:0] wr_ptr_reg;
    logic [CNT_BITS-1:0]  position_reg;
    logic [CNT_BITS-1:0]  position_next;
    logic                 s1_valid_reg;
    s1_item_t             s1_item_reg;
    s1_item_t             s1_item_next;

    logic [WS_BITS-1:0]   k_eff;
    logic [CNT_BITS-1:0]  k_ext;
    logic [CNT_BITS-1:0]  pos_cur;
    logic [CNT_BITS-1:0]  start_wide;

    // Window size as used: zero acts as one, oversize values as the maximum.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_eff = WS_BITS'(1);
        end
        else if (window_size_reg > WS_MAX)
        begin
            k_eff = WS_MAX;
        end
        else
        begin
            k_eff = window_size_reg;
        end
    end

    assign k_ext   = CNT_BITS'(k_eff);
    assign pos_cur = in_first ? '0 : position_reg;

    // Position of the window's first sample; only meaningful once the window is full.
    assign start_wide = pos_cur + CNT_BITS'(1) - k_ext;

    always_comb
    begin
        s1_item_next.first     = in_first;
        s1_item_next.sample    = signed'(in_sample);
        s1_item_next.sub_old   = (pos_cur >= k_ext);
        s1_item_next.full      = ((pos_cur + CNT_BITS'(1)) >= k_ext);
        s1_item_next.start_pos = start_wide[POS_BITS] ? POS_SAT : start_wide[POS_BITS-1:0];
        s1_item_next.end_pos   = pos_cur[POS_BITS] ? POS_SAT : pos_cur[POS_BITS-1:0];
        position_next          = (pos_cur < CNT_LIMIT) ? pos_cur + CNT_BITS'(1) : pos_cur;
    end

    // The new sample goes into the delay line while the sample leaving the window is read.
    assign ram_we      = accept;
    assign ram_wr_addr = wr_ptr_reg;
    assign ram_wr_data = in_sample;
    assign ram_rd_addr = wr_ptr_reg - k_eff[ADDR_BITS-1:0];

    // Control state: window size, pointer, count and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_RESET;
            wr_ptr_reg      <= '0;
            position_reg    <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_size_reg <= cfg_wr_data;
                position_reg    <= '0;
            end
            else if (accept)
            begin
                position_reg <= position_next;
            end
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + ADDR_BITS'(1);
            end
            if (pipe_en)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

// File: rtl/mwst_accum.sv
// Accumulate stage: running sum, best window tracking and the output register.
`timescale 1ns / 1ps

module mwst_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s1_valid,
    input  mwst_pkg::s1_item_t                     s1_item,
    input  logic [mwst_pkg::SAMPLE_BITS-1:0]       old_sample,
    input  logic                                   cfg_wr_en,
    input  logic                                   out_ready,
    output logic                                   pipe_en,
    output logic                                   out_valid,
    output logic                                   out_full,
    output logic [mwst_pkg::SUM_BITS-1:0]          out_sum,
    output logic [mwst_pkg::SUM_BITS-1:0]          out_best_sum,
    output logic [mwst_pkg::POS_BITS-1:0]          out_best_start,
    output logic [mwst_pkg::POS_BITS-1:0]          out_best_end
);

    import mwst_pkg::*;

    logic signed [SUM_BITS-1:0] run_sum_reg;
    logic signed [SUM_BITS-1:0] best_sum_reg;
    logic [POS_BITS-1:0]        best_start_reg;
    logic [POS_BITS-1:0]        best_end_reg;
    logic                       seeded_reg;
    logic                       out_valid_reg;

    logic signed [SUM_BITS-1:0] run_sum_next;
    logic signed [SUM_BITS-1:0] best_sum_next;
    logic [POS_BITS-1:0]        best_start_next;
    logic [POS_BITS-1:0]        best_end_next;
    logic                       seeded_next;

    logic signed [SUM_BITS:0]   base_ext;
    logic signed [SUM_BITS:0]   old_ext;
    logic signed [SUM_BITS:0]   new_ext;
    logic signed [SUM_BITS:0]   sum_wide;
    logic                       fire;
    logic                       take_best;

    // The pipeline moves whenever the output register is empty or being emptied.
    assign pipe_en = !out_valid_reg || out_ready;
    assign fire    = pipe_en && s1_valid;

    // New running sum: drop the oldest sample once the window is full, add the new one.
    always_comb
    begin
        base_ext = s1_item.first ? '0 : (SUM_BITS+1)'(run_sum_reg);
        old_ext  = s1_item.sub_old ? (SUM_BITS+1)'(signed'(old_sample)) : '0;
        new_ext  = (SUM_BITS+1)'(s1_item.sample);
        sum_wide = base_ext - old_ext + new_ext;
        run_sum_next = sum_wide[SUM_BITS-1:0];
    end

    // Best window: the first full window seeds it, only a strictly larger sum replaces it.
    always_comb
    begin
        best_sum_next   = s1_item.first ? '0 : best_sum_reg;
        best_start_next = s1_item.first ? '0 : best_start_reg;
        best_end_next   = s1_item.first ? '0 : best_end_reg;
        seeded_next     = s1_item.first ? 1'b0 : seeded_reg;
        take_best       = s1_item.full && (!seeded_next || (run_sum_next > best_sum_next));
        if (take_best)
        begin
            best_sum_next   = run_sum_next;
            best_start_next = s1_item.start_pos;
            best_end_next   = s1_item.end_pos;
            seeded_next     = 1'b1;
        end
    end

    // Sequence state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg    <= '0;
            best_sum_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            seeded_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                run_sum_reg    <= '0;
                best_sum_reg   <= '0;
                best_start_reg <= '0;
                best_end_reg   <= '0;
                seeded_reg     <= 1'b0;
            end
            else if (fire)
            begin
                run_sum_reg    <= run_sum_next;
                best_sum_reg   <= best_sum_next;
                best_start_reg <= best_start_next;
                best_end_reg   <= best_end_next;
                seeded_reg     <= seeded_next;
            end
            if (pipe_en)
            begin
                out_valid_reg <= s1_valid;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_full       <= s1_item.full;
            out_sum        <= run_sum_next;
            out_best_sum   <= best_sum_next;
            out_best_start <= best_start_next;
            out_best_end   <= best_end_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
